>>> rtl/semaphore_bank_with_timed_waits_assert.svh
// Assertion macros shared by the semaphore bank RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef SEMAPHORE_BANK_WITH_TIMED_WAITS_ASSERT_SVH
`define SEMAPHORE_BANK_WITH_TIMED_WAITS_ASSERT_SVH
`ifndef SYNTH
`define SBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("semaphore bank check failed");
`define SBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("semaphore bank check failed");
`else
`define SBT_ASSERT_IMP(lbl, ante, cons)
`define SBT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/sbt_pkg.sv
// Shared types and constants of the semaphore bank.
// No dependencies; used by the cell and the top level.
package sbt_pkg;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_SIGNAL = 2'd2,
    MODE_TICK   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    K_PASS   = 3'd0,
    K_BLOCK  = 3'd1,
    K_REL    = 3'd2,
    K_NOWAIT = 3'd3,
    K_INIT   = 3'd4,
    K_ERR    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
    logic dec;
  } cell_ctl_t;

  localparam int MAX_OUT = 16;
  localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);
  localparam logic signed [15:0] CNT_MIN = 16'sh8000;
  localparam logic signed [15:0] CNT_MAX = 16'sh7fff;

endpackage

>>> rtl/sbt_req_if.sv
// Request channel of the semaphore bank: valid/ready plus one request word.
// No dependencies.
interface sbt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [2:0]         sem_id;
  logic [3:0]         thread_id;
  logic [15:0]        timeout;
  logic signed [15:0] init_value;

  modport source (output valid, mode, sem_id, thread_id, timeout, init_value,
                  input ready);
  modport sink (input valid, mode, sem_id, thread_id, timeout, init_value,
                output ready);
endinterface

>>> rtl/sbt_rsp_if.sv
// Response channel of the semaphore bank: valid/ready plus one result word.
// No dependencies.
interface sbt_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [3:0]         out_thread;
  logic               release_status;
  logic [2:0]         out_sem;
  logic signed [15:0] sem_value;
  logic               last;

  modport source (output valid, kind, out_thread, release_status, out_sem,
                  sem_value, last, input ready);
  modport sink (input valid, kind, out_thread, release_status, out_sem,
                sem_value, last, output ready);
endinterface

>>> rtl/semaphore_bank_with_timed_waits.sv
// Bank of counting semaphores with FIFO waiters and tick-driven timeouts.
// Channel req (sink) takes one request word: init, wait, signal or tick.
// Channel rsp (source) returns result words; last marks the final word of
// a request. Init, wait and signal give exactly one word; a tick gives one
// word per thread whose timeout expires (at most 16) or none at all.
// Blocked threads sit in a chain of cells ordered by blocking time, which
// is both each semaphore's FIFO order and the tie order of equal deadlines.
// Each cell keeps its own remaining tick count; a tick counts every timed
// cell down at once unless an expired cell is still waiting to be released.
// A request is taken in state IDLE and handled in EXEC, where its result word
// is registered once the output register is free; it then shows on rsp. A
// tick counts down in EXEC unless a cell has already expired, then releases
// one expired thread per cycle in TICK while the output register is free, or
// finds in TICK that nothing expired and returns to IDLE.
// A new request is taken only after the previous one is finished.
// The output register holds a word while rsp.ready is low; the block then
// waits with the next word. Reset (rst, synchronous) zeroes all counts and
// empties the chain; the block accepts requests in the next cycle.
// Depends on sbt_pkg, sbt_req_if, sbt_rsp_if and sbt_cell.
module semaphore_bank_with_timed_waits #(
  parameter int NUM_SEMS    = 8,
  parameter int NUM_THREADS = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  sbt_req_if.sink    req,
  sbt_rsp_if.source  rsp
);

  localparam int N  = NUM_THREADS;
  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int CW = sbt_pkg::OUT_CNT_W;

  sbt_pkg::state_e state, state_next;

  logic [1:0]           mode_r;
  logic [2:0]           sem_r;
  logic [3:0]           thr_r;
  logic [TIME_BITS-1:0] tmo_r;
  logic signed [15:0]   ival_r;
  logic [CW-1:0]        n_cnt;

  logic signed [15:0] sem_count [NUM_SEMS];

  logic [N-1:0]         c_valid;
  logic [TW-1:0]        c_thread [N];
  logic [SW-1:0]        c_sem    [N];
  logic [N-1:0]         c_timed;
  logic [TIME_BITS-1:0] c_rem    [N];

  logic [N-1:0] sig_match, tick_match, rm_match, rm_first, rm_below, thr_hit;
  logic [TW-1:0] sel_thread, t_idx;
  logic [SW-1:0] sel_sem, s_idx, rd_addr;
  logic          sem_ok, thr_ok, blocked_t, others_zero, rsp_free, accept;
  logic signed [15:0] cnt, cnt_inc, cnt_dec;

  // Actions and the result word.
  logic               emit, do_remove, do_load, do_dec, cnt_we, tick_last;
  logic signed [15:0] cnt_wd;
  logic [2:0]         res_kind;
  logic [3:0]         res_thread;
  logic               res_status, res_last;
  logic [2:0]         res_sem;
  logic signed [15:0] res_value;

  logic               out_valid;
  logic [2:0]         out_kind;
  logic [3:0]         out_thread;
  logic               out_status, out_last;
  logic [2:0]         out_sem;
  logic signed [15:0] out_value;

  assign req.ready = (state == sbt_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= req.mode;
      sem_r  <= req.sem_id;
      thr_r  <= req.thread_id;
      tmo_r  <= TIME_BITS'(req.timeout);
      ival_r <= req.init_value;
    end
  end

  assign s_idx  = SW'(sem_r);
  assign t_idx  = TW'(thr_r);
  assign sem_ok = (32'(sem_r) < NUM_SEMS);
  assign thr_ok = (32'(thr_r) < NUM_THREADS);

  // Per-cell matches, then the oldest match is picked for removal.
  always_comb begin
    sel_thread = '0;
    sel_sem    = '0;
    for (int i = 0; i < N; i++) begin
      sig_match[i]  = c_valid[i] && (c_sem[i] == s_idx);
      tick_match[i] = c_valid[i] && c_timed[i] && (c_rem[i] == '0);
      thr_hit[i]    = c_valid[i] && (c_thread[i] == t_idx);
    end
    rm_match = (state == sbt_pkg::ST_TICK) ? tick_match : sig_match;
    rm_first = rm_match & (~rm_match + N'(1));
    rm_below = (rm_match - N'(1)) & ~rm_match;
    for (int i = 0; i < N; i++) begin
      sel_thread = sel_thread | (rm_first[i] ? c_thread[i] : '0);
      sel_sem    = sel_sem | (rm_first[i] ? c_sem[i] : '0);
    end
  end

  assign blocked_t   = |thr_hit;
  assign others_zero = |(tick_match & ~rm_first);
  assign tick_last   = (n_cnt == CW'(sbt_pkg::MAX_OUT - 1)) || !others_zero;

  assign rd_addr = (state == sbt_pkg::ST_TICK) ? sel_sem : s_idx;
  assign cnt     = sem_count[rd_addr];
  assign cnt_inc = (cnt == sbt_pkg::CNT_MAX) ? cnt : cnt + 16'sd1;
  assign cnt_dec = cnt - 16'sd1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sbt_pkg::ST_IDLE: begin
        if (accept) state_next = sbt_pkg::ST_EXEC;
      end
      sbt_pkg::ST_EXEC: begin
        if (mode_r == sbt_pkg::MODE_TICK) state_next = sbt_pkg::ST_TICK;
        else if (rsp_free) state_next = sbt_pkg::ST_IDLE;
      end
      sbt_pkg::ST_TICK: begin
        if (!(|tick_match)) state_next = sbt_pkg::ST_IDLE;
        else if (rsp_free && tick_last) state_next = sbt_pkg::ST_IDLE;
      end
      default: state_next = sbt_pkg::ST_IDLE;
    endcase
  end

  // Actions and result word.
  always_comb begin
    emit       = 1'b0;
    do_remove  = 1'b0;
    do_load    = 1'b0;
    do_dec     = 1'b0;
    cnt_we     = 1'b0;
    cnt_wd     = cnt;
    res_kind   = sbt_pkg::K_ERR;
    res_thread = thr_r;
    res_status = 1'b0;
    res_sem    = sem_r;
    res_value  = cnt;
    res_last   = 1'b1;
    case (state)
      sbt_pkg::ST_EXEC: begin
        if (mode_r == sbt_pkg::MODE_TICK) begin
          do_dec = !(|tick_match);
        end else if (rsp_free) begin
          emit = 1'b1;
          if (!sem_ok) begin
            res_value = '0;
          end else begin
            case (mode_r)
              sbt_pkg::MODE_INIT: begin
                cnt_we     = 1'b1;
                cnt_wd     = ival_r;
                res_kind   = sbt_pkg::K_INIT;
                res_thread = '0;
                res_value  = ival_r;
              end
              sbt_pkg::MODE_WAIT: begin
                if (thr_ok && !blocked_t && cnt != sbt_pkg::CNT_MIN) begin
                  cnt_we    = 1'b1;
                  cnt_wd    = cnt_dec;
                  res_value = cnt_dec;
                  if (cnt_dec[15]) begin
                    do_load  = 1'b1;
                    res_kind = sbt_pkg::K_BLOCK;
                  end else begin
                    res_kind   = sbt_pkg::K_PASS;
                    res_status = 1'b1;
                  end
                end
              end
              sbt_pkg::MODE_SIGNAL: begin
                cnt_we = 1'b1;
                if (cnt[15] && (|sig_match)) begin
                  do_remove  = 1'b1;
                  cnt_wd     = cnt + 16'sd1;
                  res_value  = cnt + 16'sd1;
                  res_kind   = sbt_pkg::K_REL;
                  res_thread = 4'(sel_thread);
                  res_status = 1'b1;
                end else begin
                  cnt_wd     = cnt_inc;
                  res_value  = cnt_inc;
                  res_kind   = sbt_pkg::K_NOWAIT;
                  res_thread = '0;
                end
              end
              default: emit = 1'b0;
            endcase
          end
        end
      end
      sbt_pkg::ST_TICK: begin
        if ((|tick_match) && rsp_free) begin
          emit       = 1'b1;
          do_remove  = 1'b1;
          cnt_we     = 1'b1;
          cnt_wd     = cnt_inc;
          res_kind   = sbt_pkg::K_REL;
          res_thread = 4'(sel_thread);
          res_sem    = 3'(sel_sem);
          res_value  = cnt_inc;
          res_last   = tick_last;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbt_pkg::ST_IDLE;
      n_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) n_cnt <= '0;
      else if (emit) n_cnt <= n_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SEMS; i++) sem_count[i] <= '0;
    end else if (cnt_we) begin
      sem_count[rd_addr] <= cnt_wd;
    end
  end

  // The chain: cell i takes cell i+1 when a cell at or below i leaves.
  for (genvar i = 0; i < N; i++) begin : g_cell
    sbt_pkg::cell_ctl_t   ctl;
    logic                 nb_valid;
    logic [TW-1:0]        nb_thread;
    logic [SW-1:0]        nb_sem;
    logic                 nb_timed;
    logic [TIME_BITS-1:0] nb_rem;
    logic                 free_slot;

    if (i == N - 1) begin : g_end
      assign nb_valid  = 1'b0;
      assign nb_thread = '0;
      assign nb_sem    = '0;
      assign nb_timed  = 1'b0;
      assign nb_rem    = '0;
    end else begin : g_mid
      assign nb_valid  = c_valid[i+1];
      assign nb_thread = c_thread[i+1];
      assign nb_sem    = c_sem[i+1];
      assign nb_timed  = c_timed[i+1];
      assign nb_rem    = c_rem[i+1];
    end

    if (i == 0) begin : g_first
      assign free_slot = !c_valid[0];
    end else begin : g_rest
      assign free_slot = c_valid[i-1] && !c_valid[i];
    end

    assign ctl.shift = do_remove && !rm_below[i];
    assign ctl.load  = do_load && free_slot;
    assign ctl.dec   = do_dec;

    sbt_cell #(
      .TW (TW),
      .SW (SW),
      .TB (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .nb_valid  (nb_valid),
      .nb_thread (nb_thread),
      .nb_sem    (nb_sem),
      .nb_timed  (nb_timed),
      .nb_rem    (nb_rem),
      .ld_thread (t_idx),
      .ld_sem    (s_idx),
      .ld_timed  (tmo_r != '0),
      .ld_rem    (tmo_r),
      .valid     (c_valid[i]),
      .thread    (c_thread[i]),
      .sem       (c_sem[i]),
      .timed     (c_timed[i]),
      .rem       (c_rem[i])
    );
  end

  // Output register decouples the receiver from the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= res_kind;
      out_thread <= res_thread;
      out_status <= res_status;
      out_sem    <= res_sem;
      out_value  <= res_value;
      out_last   <= res_last;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.kind           = out_kind;
  assign rsp.out_thread     = out_thread;
  assign rsp.release_status = out_status;
  assign rsp.out_sem        = out_sem;
  assign rsp.sem_value      = out_value;
  assign rsp.last           = out_last;

`include "semaphore_bank_with_timed_waits_assert.svh"

  `SBT_ASSERT_IMP(a_chain_packed, 1'b1, (c_valid & (c_valid + N'(1))) == '0)
  `SBT_ASSERT_NXT(a_accept_exec, accept, state == sbt_pkg::ST_EXEC)
  `SBT_ASSERT_IMP(a_idle_quiet, state == sbt_pkg::ST_IDLE, !emit && !do_remove)
  `SBT_ASSERT_IMP(a_tick_cap, state == sbt_pkg::ST_TICK, n_cnt < CW'(sbt_pkg::MAX_OUT))

endmodule

>>> rtl/sbt_cell.sv
// One slot of the waiter chain: a blocked thread, its semaphore and timeout.
// Depends on sbt_pkg for the control struct.
module sbt_cell #(
  parameter int TW = 4,
  parameter int SW = 3,
  parameter int TB = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  sbt_pkg::cell_ctl_t ctl,
  input  logic               nb_valid,
  input  logic [TW-1:0]      nb_thread,
  input  logic [SW-1:0]      nb_sem,
  input  logic               nb_timed,
  input  logic [TB-1:0]      nb_rem,
  input  logic [TW-1:0]      ld_thread,
  input  logic [SW-1:0]      ld_sem,
  input  logic               ld_timed,
  input  logic [TB-1:0]      ld_rem,
  output logic               valid,
  output logic [TW-1:0]      thread,
  output logic [SW-1:0]      sem,
  output logic               timed,
  output logic [TB-1:0]      rem
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= nb_valid;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end
  end

  // A removal closes the gap by taking the younger neighbor's contents.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      thread <= nb_thread;
      sem    <= nb_sem;
      timed  <= nb_timed;
      rem    <= nb_rem;
    end else if (ctl.load) begin
      thread <= ld_thread;
      sem    <= ld_sem;
      timed  <= ld_timed;
      rem    <= ld_rem;
    end else if (ctl.dec && timed && rem != '0) begin
      rem <= rem - 1'b1;
    end
  end

endmodule

>>> tb/sbt_checker.sv
// Watches the request and result channels of the semaphore bank, predicts
// every result word from its own model of the bank and compares them in order.
// Depends on sbt_pkg, sbt_req_if and sbt_rsp_if.
module sbt_checker (
  input  logic clk,
  input  logic rst,
  sbt_req_if   req,
  sbt_rsp_if   rsp,
  output int   errors,
  output int   pending,
  output int   n_reqs,
  output int   n_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIL = -1;

  typedef struct {
    sbt_pkg::kind_e     kind;
    logic [3:0]         thr;
    logic               status;
    logic [2:0]         sem;
    logic signed [15:0] value;
    logic               last;
  } word_t;

  word_t expected_words[$];

  int count[8];
  int fifo_head[8];
  int fifo_tail[8];
  int fifo_next[16];
  bit blocked[16];
  bit timed[16];
  int wait_sem[16];
  int delay[16];
  int delay_next[16];
  int delay_head;

  function automatic void push_word(sbt_pkg::kind_e k, int thr, bit st, int s, int v);
    word_t w;
    w.kind = k;
    w.thr = thr[3:0];
    w.status = st;
    w.sem = s[2:0];
    w.value = v[15:0];
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void bump(int s);
    if (count[s] < 32767) count[s]++;
  endfunction

  function automatic void timer_insert(int t, int ticks);
    int cur;
    int prev;
    cur = delay_head;
    prev = NIL;
    while (cur != NIL && delay[cur] <= ticks) begin
      ticks -= delay[cur];
      prev = cur;
      cur = delay_next[cur];
    end
    delay[t] = ticks;
    delay_next[t] = cur;
    if (prev != NIL) delay_next[prev] = t;
    else delay_head = t;
    if (cur != NIL) delay[cur] -= ticks;
  endfunction

  function automatic void timer_unlink(int t);
    int cur;
    int prev;
    cur = delay_head;
    prev = NIL;
    while (cur != NIL && cur != t) begin
      prev = cur;
      cur = delay_next[cur];
    end
    if (cur == NIL) return;
    if (delay_next[cur] != NIL)
      delay[delay_next[cur]] = (delay[delay_next[cur]] + delay[cur]) & 16'hffff;
    if (prev != NIL) delay_next[prev] = delay_next[cur];
    else delay_head = delay_next[cur];
  endfunction

  function automatic void fifo_unlink(int s, int t);
    int cur;
    int prev;
    cur = fifo_head[s];
    prev = NIL;
    while (cur != NIL && cur != t) begin
      prev = cur;
      cur = fifo_next[cur];
    end
    if (cur == NIL) return;
    if (prev != NIL) fifo_next[prev] = fifo_next[cur];
    else fifo_head[s] = fifo_next[cur];
    if (fifo_next[cur] == NIL) fifo_tail[s] = prev;
  endfunction

  // Applies one request to the model and queues the words it causes.
  function automatic void apply_request(sbt_pkg::mode_e m, int s, int t, int tmo, int ival);
    int n;
    int x;
    n = expected_words.size();
    if (m == sbt_pkg::MODE_TICK) begin
      if (delay_head != NIL && delay[delay_head] > 0) delay[delay_head]--;
      while (expected_words.size() - n < sbt_pkg::MAX_OUT && delay_head != NIL &&
             delay[delay_head] == 0) begin
        x = delay_head;
        delay_head = delay_next[x];
        fifo_unlink(wait_sem[x], x);
        blocked[x] = 0;
        timed[x] = 0;
        bump(wait_sem[x]);
        push_word(sbt_pkg::K_REL, x, 0, wait_sem[x], count[wait_sem[x]]);
      end
    end else if (m == sbt_pkg::MODE_INIT) begin
      count[s] = ival;
      push_word(sbt_pkg::K_INIT, 0, 0, s, count[s]);
    end else if (m == sbt_pkg::MODE_WAIT) begin
      if (blocked[t] || count[s] <= -32768) begin
        push_word(sbt_pkg::K_ERR, t, 0, s, count[s]);
      end else if (--count[s] >= 0) begin
        push_word(sbt_pkg::K_PASS, t, 1, s, count[s]);
      end else begin
        blocked[t] = 1;
        timed[t] = tmo > 0;
        wait_sem[t] = s;
        fifo_next[t] = NIL;
        if (fifo_head[s] != NIL) fifo_next[fifo_tail[s]] = t;
        else fifo_head[s] = t;
        fifo_tail[s] = t;
        if (tmo > 0) timer_insert(t, tmo);
        push_word(sbt_pkg::K_BLOCK, t, 0, s, count[s]);
      end
    end else begin
      if (count[s] + 1 <= 0 && fifo_head[s] != NIL) begin
        x = fifo_head[s];
        fifo_head[s] = fifo_next[x];
        if (fifo_head[s] == NIL) fifo_tail[s] = NIL;
        if (timed[x]) timer_unlink(x);
        blocked[x] = 0;
        timed[x] = 0;
        count[s]++;
        push_word(sbt_pkg::K_REL, x, 1, s, count[s]);
      end else begin
        bump(s);
        push_word(sbt_pkg::K_NOWAIT, 0, 0, s, count[s]);
      end
    end
    if (expected_words.size() > n)
      expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        count[i] = 0;
        fifo_head[i] = NIL;
        fifo_tail[i] = NIL;
      end
      for (int i = 0; i < 16; i++) begin
        blocked[i] = 0;
        timed[i] = 0;
        fifo_next[i] = 0;
        wait_sem[i] = 0;
        delay[i] = 0;
        delay_next[i] = 0;
      end
      delay_head = NIL;
      expected_words.delete();
      errors = 0;
      n_reqs = 0;
      n_words = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        n_words++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result word kind=%0d thread=%0d sem=%0d", $realtime,
                     rsp.kind, rsp.out_thread, rsp.out_sem);
        end else begin
          w = expected_words.pop_front();
          if (rsp.kind !== w.kind || rsp.out_thread !== w.thr ||
              rsp.release_status !== w.status || rsp.out_sem !== w.sem ||
              rsp.sem_value !== w.value || rsp.last !== w.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp kind=%0d thr=%0d st=%0d sem=%0d val=%0d last=%0d",
                       $realtime, w.kind, w.thr, w.status, w.sem, w.value, w.last,
                       " got kind=%0d thr=%0d st=%0d sem=%0d val=%0d last=%0d",
                       rsp.kind, rsp.out_thread, rsp.release_status, rsp.out_sem,
                       rsp.sem_value, rsp.last);
          end
        end
      end
      if (req.valid && req.ready) begin
        n_reqs++;
        apply_request(sbt_pkg::mode_e'(req.mode), req.sem_id, req.thread_id, req.timeout,
                      req.init_value);
      end
    end
    pending = expected_words.size();
  end

  // Words still owed at the end count as failures.
  function automatic int leftover();
    return expected_words.size();
  endfunction
endmodule

>>> tb/semaphore_bank_with_timed_waits_tb.sv
// Top of the semaphore bank testbench: clock, reset, request stimulus and
// result-side stalls; checking is done by sbt_checker.
// Depends on sbt_pkg, sbt_req_if, sbt_rsp_if, sbt_checker and the block.
module semaphore_bank_with_timed_waits_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 0;
  int   errors;
  int   pending;
  int   n_reqs;
  int   n_words;
  int   quiet_cycles = 0;

  sbt_req_if req ();
  sbt_rsp_if rsp ();

  semaphore_bank_with_timed_waits u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  sbt_checker u_chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .errors(errors),
                     .pending(pending), .n_reqs(n_reqs), .n_words(n_words));

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("semaphore_bank_with_timed_waits_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Drives one request word and returns at the edge that accepts it.
  task automatic issue(sbt_pkg::mode_e m, int s, int t, int tmo, int ival);
    bit rdy;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= m;
    req.sem_id <= s[2:0];
    req.thread_id <= t[3:0];
    req.timeout <= tmo[15:0];
    req.init_value <= ival[15:0];
    do begin
      @(negedge clk);
      rdy = req.ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  function automatic int pick_timeout();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return 0;
    if (r < 17) return $urandom_range(1, 12);
    return $urandom_range(0, 65535);
  endfunction

  initial begin
    int r;
    req.valid = 1'b0;
    req.mode = sbt_pkg::MODE_INIT;
    req.sem_id = '0;
    req.thread_id = '0;
    req.timeout = '0;
    req.init_value = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Saturation at the ceiling, error at the floor, then a forever waiter.
    issue(sbt_pkg::MODE_INIT, 0, 0, 0, 32767);
    issue(sbt_pkg::MODE_SIGNAL, 0, 0, 0, 0);
    issue(sbt_pkg::MODE_INIT, 1, 0, 0, -32768);
    issue(sbt_pkg::MODE_WAIT, 1, 0, 5, 0);
    issue(sbt_pkg::MODE_INIT, 1, 0, 0, 0);
    issue(sbt_pkg::MODE_WAIT, 1, 0, 0, 0);
    issue(sbt_pkg::MODE_WAIT, 1, 0, 3, 0);
    issue(sbt_pkg::MODE_SIGNAL, 1, 0, 0, 0);
    issue(sbt_pkg::MODE_TICK, 7, 15, 65535, -1);
    issue(sbt_pkg::MODE_INIT, 3, 0, 0, -5);
    issue(sbt_pkg::MODE_SIGNAL, 3, 0, 0, 0);
    // All sixteen threads expire on the same tick.
    issue(sbt_pkg::MODE_INIT, 2, 0, 0, 0);
    for (int t = 0; t < 16; t++) issue(sbt_pkg::MODE_WAIT, 2, t, 2, 0);
    issue(sbt_pkg::MODE_TICK, 0, 0, 0, 0);
    issue(sbt_pkg::MODE_TICK, 0, 0, 0, 0);

    for (int i = 0; i < 430; i++) begin
      if (i == 355) calm = 1;
      r = $urandom_range(0, 99);
      if (r < 12)
        issue(sbt_pkg::MODE_INIT, $urandom_range(0, 7), $urandom_range(0, 15),
              $urandom_range(0, 65535),
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2));
      else if (r < 45)
        issue(sbt_pkg::MODE_WAIT,
              $urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(0, 7),
              $urandom_range(0, 15), pick_timeout(), $urandom_range(0, 65535));
      else if (r < 70)
        issue(sbt_pkg::MODE_SIGNAL,
              $urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(0, 7),
              $urandom_range(0, 15), $urandom_range(0, 65535), $urandom_range(0, 65535));
      else
        issue(sbt_pkg::MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 15),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d requests (init, wait, signal, tick) and checked %0d result words.",
             n_reqs, n_words);
    if (errors == 0 && u_chk.leftover() == 0) begin
      $display("semaphore_bank_with_timed_waits_tb: done, clean");
    end else begin
      $display("semaphore_bank_with_timed_waits_tb: done, errors");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/sbt_pkg.sv
rtl/sbt_req_if.sv
rtl/sbt_rsp_if.sv
rtl/sbt_cell.sv
rtl/semaphore_bank_with_timed_waits.sv
tb/sbt_checker.sv
tb/semaphore_bank_with_timed_waits_tb.sv
